/* design/pmfb_pkg.sv */
// Package for the paged monochrome framebuffer drawing engine.
// Holds screen geometry, the command codes and the sequencer state type.
package pmfb_pkg;

  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 32;
  localparam int PageCount    = 4;
  localparam int StoreBytes   = PageCount * ScreenWidth;
  localparam int AddrW        = $clog2(StoreBytes);
  localparam int ColW         = $clog2(ScreenWidth);
  localparam int PageW        = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int Rows         = (ScreenHeight < PageCount * 8) ? ScreenHeight : PageCount * 8;

  // Last column and row that are drawn, as span coordinates
  localparam logic signed [10:0] XMax = 11'(ScreenWidth - 1);
  localparam logic signed [10:0] YMax = 11'(Rows - 1);

  // floor(n / 100) = (n * RecipHundred) >> RecipShift for any n below 2**15
  localparam logic [15:0] RecipHundred = 16'd20972;
  localparam int          RecipShift   = 21;

  typedef enum logic [3:0] {
    OP_PIXEL    = 4'd0,
    OP_HLINE    = 4'd1,
    OP_VLINE    = 4'd2,
    OP_RECT     = 4'd3,
    OP_FILL     = 4'd4,
    OP_PROGRESS = 4'd5,
    OP_BITMAP   = 4'd6,
    OP_CLEAR    = 4'd7,
    OP_READ     = 4'd8
  } op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_SCALE,
    ST_SPAN,
    ST_RD,
    ST_WR,
    ST_CLEAR,
    ST_RDATA,
    ST_DONE
  } state_t;

endpackage

/* design/paged_mono_framebuffer_draw.sv */
// Top level of the paged monochrome framebuffer drawing engine.
// Depends on pmfb_pkg for geometry, command codes and the state type.
//
// Every drawing command is broken into up to six rectangles of pixels (spans):
// one for a pixel, line, filled rectangle or bitmap row, four for an outline,
// and four outline sides plus a fill and a clear area for a progress bar. Each
// span is clipped to the screen, then walked a byte at a time (column by
// column, page by page) with a read-modify-write on the byte store. The
// progress bar's fill width is computed first on one shared 16x16 multiplier
// (inner width times percent, then times a reciprocal of 100). A clear sweeps
// the 512 bytes at one a cycle. After reset the store is swept to zero before
// the first word is taken. One word is taken at a time; ready is low while a
// command runs and until its result word has been taken.
module paged_mono_framebuffer_draw
  import pmfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        operation,
  input  logic signed [8:0] x,
  input  logic signed [8:0] y,
  input  logic signed [8:0] end_coord,
  input  logic [7:0]        width,
  input  logic [7:0]        height,
  input  logic              color,
  input  logic signed [7:0] percent,
  input  logic [15:0]       bitmap_bits,
  input  logic [3:0]        bitmap_row,
  input  logic [1:0]        page,
  input  logic [6:0]        column,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_data,
  output logic              is_read
);

  state_t state, state_next;

  // Latched command
  logic [3:0]         op;
  logic signed [10:0] cx, cy, ce, cw, ch, brow;
  logic               ccol;
  logic [6:0]         pct;
  logic [15:0]        bits;
  logic [AddrW-1:0]   raddr;

  // Span walk
  logic [2:0]         sidx;
  logic [2:0]         sidx_last;
  logic [ColW-1:0]    col;
  logic [PageW-1:0]   pg;
  logic [AddrW-1:0]   clr_addr;

  // Shared multiplier for the bar fill width
  logic [15:0] prod;
  logic [7:0]  fw;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;

  // Byte store
  logic [7:0]       mem [StoreBytes];
  logic [7:0]       mdata;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  // Current span, before and after clipping
  logic               sp_ok, sp_on, sp_bm;
  logic signed [10:0] sp_x0, sp_x1, sp_y0, sp_y1;
  logic signed [10:0] cl_x0, cl_x1, cl_y0, cl_y1;
  logic               span_go;

  // Byte walk helpers
  logic [PageW-1:0]   pg0, pg1;
  logic [ColW-1:0]    col_end;
  logic               byte_last;
  logic [2:0]         lo_bit, hi_bit;
  logic [7:0]         mask;
  logic signed [10:0] boff;
  logic               pix_val;
  logic [7:0]         merged;

  // Command geometry
  logic signed [10:0] x_right, y_bottom, iw, ih, fw11;
  logic               has_area;
  logic [7:0]         iw_pos;
  assign x_right  = cx + cw - 11'sd1;
  assign y_bottom = cy + ch - 11'sd1;
  assign iw       = cw - 11'sd2;
  assign ih       = ch - 11'sd2;
  assign fw11     = signed'({3'b000, fw});
  assign has_area = (cw != 11'sd0) && (ch != 11'sd0);
  assign iw_pos   = (iw > 11'sd0) ? iw[7:0] : 8'd0;

  assign sidx_last = (op == OP_PROGRESS) ? 3'd5 : (op == OP_RECT) ? 3'd3 : 3'd0;

  // Span for the current slot
  always_comb begin
    sp_ok = 1'b0; sp_x0 = cx; sp_x1 = cx; sp_y0 = cy; sp_y1 = cy;
    sp_on = ccol; sp_bm = 1'b0;
    case (op)
      OP_PIXEL: sp_ok = 1'b1;
      OP_HLINE: begin
        sp_ok = 1'b1;
        sp_x0 = (cx > ce) ? ce : cx; sp_x1 = (cx > ce) ? cx : ce;
      end
      OP_VLINE: begin
        sp_ok = 1'b1;
        sp_y0 = (cy > ce) ? ce : cy; sp_y1 = (cy > ce) ? cy : ce;
      end
      OP_FILL: begin
        sp_ok = has_area; sp_x1 = x_right; sp_y1 = y_bottom;
      end
      OP_BITMAP: begin
        sp_ok = 1'b1; sp_x1 = cx + 11'sd15; sp_y0 = cy + brow; sp_y1 = cy + brow;
        sp_bm = 1'b1;
      end
      OP_RECT, OP_PROGRESS: begin
        // outline always set for the bar
        if (op == OP_PROGRESS) sp_on = 1'b1;
        case (sidx)
          3'd0: begin
            sp_ok = has_area; sp_x1 = x_right;
          end
          3'd1: begin
            sp_ok = has_area; sp_x1 = x_right; sp_y0 = y_bottom; sp_y1 = y_bottom;
          end
          3'd2: begin
            sp_ok = has_area; sp_y1 = y_bottom;
          end
          3'd3: begin
            sp_ok = has_area; sp_x0 = x_right; sp_x1 = x_right; sp_y1 = y_bottom;
          end
          3'd4: begin
            // filled part of the bar
            sp_ok = (op == OP_PROGRESS) && (fw11 > 11'sd0) && (ih > 11'sd0);
            sp_x0 = cx + 11'sd1; sp_x1 = cx + fw11;
            sp_y0 = cy + 11'sd1; sp_y1 = cy + ih;
          end
          3'd5: begin
            // rest of the inner area, cleared
            sp_ok = (op == OP_PROGRESS) && (iw > fw11) && (ih > 11'sd0);
            sp_x0 = cx + 11'sd1 + fw11; sp_x1 = cx + iw;
            sp_y0 = cy + 11'sd1; sp_y1 = cy + ih;
            sp_on = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Clip to the screen
  assign cl_x0   = (sp_x0 < 11'sd0) ? 11'sd0 : sp_x0;
  assign cl_x1   = (sp_x1 > XMax) ? XMax : sp_x1;
  assign cl_y0   = (sp_y0 < 11'sd0) ? 11'sd0 : sp_y0;
  assign cl_y1   = (sp_y1 > YMax) ? YMax : sp_y1;
  assign span_go = sp_ok && (cl_x0 <= cl_x1) && (cl_y0 <= cl_y1);

  // Bits of the current byte inside the span, and their new value
  assign pg0       = cl_y0[PageW+2:3];
  assign pg1       = cl_y1[PageW+2:3];
  assign col_end   = cl_x1[ColW-1:0];
  assign byte_last = (pg == pg1) && (col == col_end);
  assign lo_bit    = (pg == pg0) ? cl_y0[2:0] : 3'd0;
  assign hi_bit    = (pg == pg1) ? cl_y1[2:0] : 3'd7;
  assign mask      = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
  assign boff      = signed'(11'(col)) - cx;
  assign pix_val   = sp_bm ? bits[4'd15 - boff[3:0]] : sp_on;
  assign merged    = (mdata & ~mask) | (pix_val ? mask : 8'h00);

  // Shared multiplier: inner width times percent, then times 1/100
  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = prod; mul_b = RecipHundred;
    end else begin
      mul_a = {8'd0, iw_pos}; mul_b = {9'd0, pct};
    end
  end
  assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

  // Store ports
  always_comb begin
    mem_we    = (state == ST_CLEAR) || (state == ST_WR);
    mem_re    = (state == ST_RD) || (state == ST_RDATA);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : {pg, col};
    mem_wdata = (state == ST_CLEAR) ? 8'd0 : merged;
    mem_raddr = (state == ST_RDATA) ? raddr : {pg, col};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mdata <= mem[mem_raddr];
  end

  assign read_data = is_read ? mdata : 8'd0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AddrW'(StoreBytes - 1))
                  state_next = (op == OP_CLEAR) ? ST_DONE : ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_SETUP;
      ST_SETUP: begin
        case (op)
          OP_CLEAR:    state_next = ST_CLEAR;
          OP_READ:     state_next = ST_RDATA;
          OP_PROGRESS: state_next = ST_MUL;
          OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT, OP_FILL, OP_BITMAP:
            state_next = ST_SPAN;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SPAN;
      ST_SPAN: begin
        if (span_go)
          state_next = ST_RD;
        else if (sidx == sidx_last)
          state_next = ST_DONE;
      end
      ST_RD:    state_next = ST_WR;
      ST_WR: begin
        if (!byte_last)
          state_next = ST_RD;
        else
          state_next = (sidx == sidx_last) ? ST_DONE : ST_SPAN;
      end
      ST_RDATA: state_next = ST_DONE;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; clr_addr <= '0; op <= OP_PIXEL; is_read <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: if (in_valid) begin
          op <= operation; cx <= 11'(x); cy <= 11'(y); ce <= 11'(end_coord);
          cw <= signed'({3'b000, width}); ch <= signed'({3'b000, height});
          ccol <= color; bits <= bitmap_bits;
          brow <= signed'({7'd0, bitmap_row});
          pct <= (percent < 8'sd0) ? 7'd0 : (percent > 8'sd100) ? 7'd100 : percent[6:0];
          raddr <= {page, column};
          is_read <= (operation == OP_READ);
        end
        ST_SETUP: sidx <= 3'd0;
        ST_MUL:   prod <= mul_p[15:0];
        ST_SCALE: fw <= mul_p[RecipShift+7:RecipShift];
        ST_SPAN: begin
          if (span_go) begin
            col <= cl_x0[ColW-1:0]; pg <= pg0;
          end else if (sidx != sidx_last) begin
            sidx <= sidx + 3'd1;
          end
        end
        ST_WR: begin
          // pages of a column first, then the next column
          if (byte_last) begin
            if (sidx != sidx_last) sidx <= sidx + 3'd1;
          end else if (pg == pg1) begin
            pg <= pg0; col <= col + 1'b1;
          end else begin
            pg <= pg + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result word held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(is_read));

  // No new word while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid));

  // Only a read returns data
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_read |-> read_data == 8'd0);

  // Every byte read for a span is written back on the next cycle
  a_rmw_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> state == ST_WR);

endmodule
